// ===== design/tti_pkg.sv =====
// Shared constants and types for the trajectory time interpolator.
package tti_pkg;
  localparam int MaxPointsDef = 64;
  localparam int NVal = 6;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdQuery  = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;
  localparam logic [1:0] StOrder = 2'd3;

  // divider control between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quo;
  } div_rsp_t;
endpackage

// ===== design/tti_div.sv =====
// Radix-2 restoring divider producing a 17-bit quotient, one bit a cycle.
module tti_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tti_pkg::div_req_t req,
  output tti_pkg::div_rsp_t rsp
);
  logic [32:0] rem_r, rem_nxt;
  logic [47:0] num_r, num_nxt;
  logic [32:0] den_r, den_nxt;
  logic [16:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;
  logic [33:0] shifted;

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, num_r[47]};
    trial    = shifted - {1'b0, den_r};
    if (req.start) begin
      // quotient < 2^17: leading 31 numerator bits form the start remainder
      rem_nxt  = {2'b00, req.num[47:17]};
      num_nxt  = {req.num[16:0], 31'd0};
      den_nxt  = req.den;
      cnt_nxt  = 5'd17;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[46:0], 1'b0};
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[15:0], 1'b1};
      end else begin
        rem_nxt = shifted[32:0];
        quo_nxt = {quo_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

// ===== design/trajectory_time_interpolator.sv =====
// Top level: point table, binary-search sequencer and shared interpolation unit.
//
// Every command takes one transaction in and gives one out. Clear, an unknown command, a query
// on an empty table and an append to a full table go straight to the result; an append first
// reads the last stored time to check the order, then writes the point. An end-clamped query
// returns the first or last point. An interior query runs the binary search (up to six steps
// at 64 points) and fetches the bracketing times, then runs the serial fraction divider and
// passes each of the six values through the single 33x18 multiplier; a query that hits a stored
// time exactly returns that point instead. The input is not ready while a command is in progress
// or its result waits. The tables are single-port memories with no reset; only the point count
// is cleared.
module trajectory_time_interpolator #(
  parameter int MAX_POINTS = tti_pkg::MaxPointsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd[1:0], stamp[33:2], pos_x, pos_y, pos_z, roll_in, pitch_in, yaw_in, pad 6
  input  logic [231:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], out_stamp, out_x, out_y, out_z, out_roll, out_pitch, out_yaw,
  // twist_index[231:226]
  output logic [231:0] out_tdata
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_APP_RD, S_APP_CHK, S_APP_WR, S_Q0, S_Q1, S_QEND, S_SRCH, S_SRCHW,
    S_RIGHT, S_DIV, S_VRD, S_VMUL, S_EMIT, S_OUT
  } state_t;

  logic [31:0] time_mem [MAX_POINTS];
  logic [31:0] val_mem  [MAX_POINTS * tti_pkg::NVal];
  localparam int VAW = $clog2(MAX_POINTS * tti_pkg::NVal);

  state_t      st_r;
  logic [CW-1:0] cnt_r;
  logic [31:0] t_r;
  logic [31:0] vin_r [tti_pkg::NVal];
  logic [AW-1:0] lo_r, hi_r, idx_r, left_r;
  logic [31:0] tr_r, trd_r;
  logic [16:0] frac_r;
  logic [2:0]  k_r;
  logic        ph_r;
  logic [31:0] va_r;
  logic [31:0] res_r [tti_pkg::NVal];
  logic [1:0]  status_r;
  logic [31:0] ostamp_r;
  logic [5:0]  twist_r;
  logic        oval_r;
  logic        emit_pt_r;

  logic        t_we;
  logic [AW-1:0] t_addr;
  logic        v_we;
  logic [VAW-1:0] v_addr;
  logic [31:0] v_wd;
  logic [31:0] vrd_r;
  logic [AW-1:0] mid;
  logic [AW-1:0] last;
  logic [65:0] prod;
  logic [49:0] prod_r;
  logic [32:0] diff_r;

  tti_pkg::div_req_t dreq;
  tti_pkg::div_rsp_t drsp;

  tti_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign last = AW'(cnt_r - CW'(1));
  assign mid  = lo_r + ((hi_r - lo_r) >> 1);
  // left time is on the read port during the first divide cycle
  assign dreq.start = (st_r == S_DIV) && !ph_r;
  assign dreq.num   = {(t_r - trd_r), 16'd0};
  assign dreq.den   = {1'b0, tr_r - trd_r};

  always_comb begin
    t_we   = 1'b0;
    v_we   = 1'b0;
    t_addr = idx_r;
    v_addr = VAW'(idx_r * tti_pkg::NVal + k_r);
    v_wd   = vin_r[k_r];
    if (st_r == S_APP_WR) begin
      t_addr = cnt_r[AW-1:0];
      t_we   = (k_r == 3'd0);
      v_we   = 1'b1;
      v_addr = VAW'(cnt_r[AW-1:0] * tti_pkg::NVal + k_r);
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) time_mem[t_addr] <= t_r;
    trd_r <= time_mem[t_addr];
    if (v_we) val_mem[v_addr] <= v_wd;
    vrd_r <= val_mem[v_addr];
  end

  // signed (b - a) * frac, frac < 2^16
  assign prod = $signed(diff_r) * $signed({1'b0, frac_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_tvalid) begin
          t_r   <= in_tdata[33:2];
          for (int i = 0; i < tti_pkg::NVal; i++) vin_r[i] <= in_tdata[34 + 32*i +: 32];
          status_r <= tti_pkg::StOk;
          ostamp_r <= '0;
          twist_r  <= '0;
          for (int i = 0; i < tti_pkg::NVal; i++) res_r[i] <= '0;
          k_r <= '0;
          ph_r <= 1'b0;
          emit_pt_r <= 1'b0;
          unique case (in_tdata[1:0])
            tti_pkg::CmdClear: begin cnt_r <= '0; st_r <= S_OUT; end
            tti_pkg::CmdAppend: begin
              if (cnt_r >= CW'(MAX_POINTS)) begin
                status_r <= tti_pkg::StFull; st_r <= S_OUT;
              end else begin
                idx_r <= AW'(cnt_r - CW'(1)); st_r <= S_APP_RD;
              end
            end
            tti_pkg::CmdQuery: begin
              if (cnt_r == '0) begin
                status_r <= tti_pkg::StEmpty; st_r <= S_OUT;
              end else begin
                idx_r <= '0; st_r <= S_Q0;
              end
            end
            default: st_r <= S_OUT;
          endcase
        end
        S_APP_RD: st_r <= S_APP_CHK;
        S_APP_CHK: begin
          if (cnt_r != '0 && t_r <= trd_r) begin
            status_r <= tti_pkg::StOrder; st_r <= S_OUT;
          end else st_r <= S_APP_WR;
        end
        S_APP_WR: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'(tti_pkg::NVal - 1)) begin
            cnt_r <= cnt_r + CW'(1); st_r <= S_OUT;
          end
        end
        S_Q0: begin idx_r <= last; st_r <= S_Q1; end
        S_Q1: begin
          // trd_r holds first time
          if (t_r <= trd_r) begin
            idx_r <= '0; st_r <= S_EMIT; emit_pt_r <= 1'b1;
          end else begin
            st_r <= S_QEND;
          end
        end
        S_QEND: begin
          if (t_r >= trd_r) begin
            idx_r <= last; st_r <= S_EMIT; emit_pt_r <= 1'b1;
          end else begin
            lo_r <= AW'(1); hi_r <= last; st_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo_r < hi_r) begin
            idx_r <= mid; st_r <= S_SRCHW; ph_r <= 1'b0;
          end else begin
            idx_r <= lo_r; st_r <= S_RIGHT; ph_r <= 1'b0;
          end
        end
        S_SRCHW: begin
          if (!ph_r) ph_r <= 1'b1;
          else begin
            if (trd_r < t_r) lo_r <= idx_r + AW'(1);
            else hi_r <= idx_r;
            st_r <= S_SRCH;
          end
        end
        S_RIGHT: begin
          if (!ph_r) begin
            ph_r <= 1'b1; idx_r <= lo_r - AW'(1);
          end else begin
            // trd_r is right time; left time read now
            tr_r <= trd_r;
            left_r <= lo_r - AW'(1);
            ph_r <= 1'b0;
            if (trd_r == t_r) begin
              idx_r <= lo_r; st_r <= S_EMIT; emit_pt_r <= 1'b1;
            end else st_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!ph_r) ph_r <= 1'b1;
          else if (drsp.done) begin
            frac_r <= drsp.quo; k_r <= '0; ph_r <= 1'b0;
            idx_r <= left_r; st_r <= S_VRD;
          end
        end
        S_VRD: begin
          // read a then b for value k
          if (!ph_r) begin ph_r <= 1'b1; idx_r <= left_r + AW'(1); end
          else begin
            va_r <= vrd_r; ph_r <= 1'b0; st_r <= S_VMUL; idx_r <= left_r;
          end
        end
        S_VMUL: begin
          if (!ph_r) begin
            diff_r <= 33'($signed(vrd_r)) - 33'($signed(va_r));
            ph_r <= 1'b1;
          end else if (!emit_pt_r) begin
            prod_r <= prod[49:0]; emit_pt_r <= 1'b1;
          end else begin
            res_r[k_r] <= va_r + prod_r[47:16];
            emit_pt_r <= 1'b0; ph_r <= 1'b0;
            if (k_r == 3'(tti_pkg::NVal - 1)) begin
              ostamp_r <= t_r; twist_r <= 6'(left_r); st_r <= S_OUT;
            end else begin
              k_r <= k_r + 3'd1; st_r <= S_VRD;
            end
          end
        end
        S_EMIT: begin
          // read point idx_r value by value; trd_r gives its time
          if (!ph_r) ph_r <= 1'b1;
          else begin
            if (k_r == '0) ostamp_r <= trd_r;
            res_r[k_r] <= vrd_r;
            if (k_r == 3'(tti_pkg::NVal - 1)) begin
              twist_r <= 6'(idx_r); st_r <= S_OUT;
            end else k_r <= k_r + 3'd1;
            ph_r <= 1'b0;
          end
        end
        S_OUT: begin
          if (!oval_r) oval_r <= 1'b1;
          else if (out_tready) begin oval_r <= 1'b0; st_r <= S_IDLE; end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = oval_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[1:0]  = status_r;
    out_tdata[33:2] = ostamp_r;
    for (int i = 0; i < tti_pkg::NVal; i++) out_tdata[34 + 32*i +: 32] = res_r[i];
    out_tdata[231:226] = twist_r;
  end
endmodule

// ===== design/tti_checker.sv =====
// Port-level checker for the trajectory time interpolator, bound to the top level.
module tti_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [231:0] out_tdata
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("ready after accept");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
  a_twist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != tti_pkg::StOk) |-> out_tdata[231:226] == 6'd0)
    else $error("twist on error status");
endmodule

bind trajectory_time_interpolator tti_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
